// ===== rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; used by the controller, the datapath and the top level.
package mexp_pkg;

  localparam int unsigned DEF_WIDTH = 64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_EBIT,
    S_SQ,
    S_DONE
  } state_e;

  // Which modular product the shared multiplier forms.
  typedef enum logic [1:0] {
    OP_REDUCE,  // 1 * base, which leaves base reduced by the modulus
    OP_MUL_R,   // result * base, written to result
    OP_SQR      // base * base, written to base
  } op_e;

  typedef struct packed {
    logic load;       // capture a new request
    logic set_one;    // result becomes 1
    logic set_zero;   // result becomes 0
    logic mul_start;  // load multiplier operands for op
    op_e  op;
    logic step;       // one multiplier bit step
    logic finish;     // write the product of this step to its destination
    logic shift_exp;  // drop the low exponent bit
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
    logic mod_one;
    logic base_zero;
    logic mul_last;
  } status_t;

endpackage

// ===== rtl/mexp_ctrl.sv =====
// Sequencer for square and multiply: issues datapath commands per exponent bit.
// Depends on mexp_pkg.
module mexp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  mexp_pkg::status_t status_i,
  output mexp_pkg::cmd_t    cmd_o,
  output logic              busy,
  output logic              done_o
);

  mexp_pkg::state_e state_q, state_d;
  mexp_pkg::op_e    op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::S_IDLE;
      op_q    <= mexp_pkg::OP_REDUCE;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      mexp_pkg::S_IDLE: begin
        if (start) state_d = mexp_pkg::S_CHECK;
      end
      mexp_pkg::S_CHECK: begin
        if (status_i.exp_zero || status_i.mod_one || status_i.base_zero) begin
          state_d = mexp_pkg::S_DONE;
        end else begin
          state_d = mexp_pkg::S_MUL;
          op_d    = mexp_pkg::OP_REDUCE;
        end
      end
      mexp_pkg::S_MUL: begin
        if (status_i.mul_last) begin
          state_d = (op_q == mexp_pkg::OP_MUL_R) ? mexp_pkg::S_SQ : mexp_pkg::S_EBIT;
        end
      end
      mexp_pkg::S_EBIT: begin
        if (status_i.exp_zero) begin
          state_d = mexp_pkg::S_DONE;
        end else if (status_i.exp_lsb) begin
          state_d = mexp_pkg::S_MUL;
          op_d    = mexp_pkg::OP_MUL_R;
        end else begin
          state_d = mexp_pkg::S_SQ;
        end
      end
      mexp_pkg::S_SQ: begin
        if (status_i.exp_rest_zero) begin
          state_d = mexp_pkg::S_DONE;
        end else begin
          state_d = mexp_pkg::S_MUL;
          op_d    = mexp_pkg::OP_SQR;
        end
      end
      mexp_pkg::S_DONE: state_d = mexp_pkg::S_IDLE;
      default:          state_d = mexp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    cmd_o.op = op_d;
    busy   = (state_q != mexp_pkg::S_IDLE);
    done_o = (state_q == mexp_pkg::S_DONE);
    unique case (state_q)
      mexp_pkg::S_IDLE: cmd_o.load = start;
      mexp_pkg::S_CHECK: begin
        // Zero exponent and unit modulus take priority over a zero base.
        if (status_i.exp_zero || status_i.mod_one) cmd_o.set_one = 1'b1;
        else if (status_i.base_zero)                cmd_o.set_zero = 1'b1;
        else                                        cmd_o.mul_start = 1'b1;
      end
      mexp_pkg::S_MUL: begin
        cmd_o.op     = op_q;
        cmd_o.step   = 1'b1;
        cmd_o.finish = status_i.mul_last;
      end
      mexp_pkg::S_EBIT: cmd_o.mul_start = !status_i.exp_zero && status_i.exp_lsb;
      mexp_pkg::S_SQ: begin
        cmd_o.shift_exp = 1'b1;
        cmd_o.mul_start = !status_i.exp_rest_zero;
      end
      mexp_pkg::S_DONE: ;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mexp_dp.sv =====
// Datapath: operand registers and a bit-serial modular multiplier, one bit a cycle.
// Depends on mexp_pkg.
module mexp_dp #(
  parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       base_i,
  input  logic [63:0]       exponent_i,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_data_i,
  input  mexp_pkg::cmd_t    cmd_i,
  output mexp_pkg::status_t status_o,
  output logic [63:0]       power_o
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] base_q, base_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] mcand_q, mcand_d;
  logic [WIDTH-1:0] mplier_q, mplier_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic             mod_zero;
  logic [WIDTH:0]   dbl, dbl_r, sum, sum_r;
  logic [WIDTH-1:0] prod;

  assign mod_zero = (mod_q == '0);

  // acc = 2*acc (+ mcand) reduced; with a zero modulus the sum simply wraps.
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (!mod_zero && dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
    sum   = {1'b0, dbl_r[WIDTH-1:0]} +
            (mplier_q[WIDTH-1] ? {1'b0, mcand_q} : '0);
    sum_r = (!mod_zero && sum >= {1'b0, mod_q}) ? sum - {1'b0, mod_q} : sum;
    prod  = sum_r[WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mod_q <= '0;
    else if (cfg_we_i) mod_q <= cfg_data_i[WIDTH-1:0];
  end

  always_comb begin
    base_d   = base_q;
    exp_d    = exp_q;
    res_d    = res_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    if (cmd_i.load) begin
      base_d = base_i[WIDTH-1:0];
      exp_d  = exponent_i[WIDTH-1:0];
      res_d  = WIDTH'(1);
    end
    if (cmd_i.set_one)  res_d = WIDTH'(1);
    if (cmd_i.set_zero) res_d = '0;
    if (cmd_i.shift_exp) exp_d = exp_q >> 1;
    if (cmd_i.mul_start) begin
      acc_d = '0;
      cnt_d = CW'(WIDTH - 1);
      unique case (cmd_i.op)
        mexp_pkg::OP_REDUCE: begin
          mcand_d  = WIDTH'(1);
          mplier_d = base_q;
        end
        mexp_pkg::OP_MUL_R: begin
          mcand_d  = base_q;
          mplier_d = res_q;
        end
        mexp_pkg::OP_SQR: begin
          mcand_d  = base_q;
          mplier_d = base_q;
        end
        default: ;
      endcase
    end
    if (cmd_i.step) begin
      acc_d    = prod;
      mplier_d = mplier_q << 1;
      cnt_d    = cnt_q - 1'b1;
    end
    if (cmd_i.finish) begin
      if (cmd_i.op == mexp_pkg::OP_MUL_R) res_d = prod;
      else                                base_d = prod;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    exp_q    <= exp_d;
    res_q    <= res_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    cnt_q    <= cnt_d;
  end

  assign status_o.exp_zero      = (exp_q == '0);
  assign status_o.exp_lsb       = exp_q[0];
  assign status_o.exp_rest_zero = ((exp_q >> 1) == '0);
  assign status_o.mod_one       = (mod_q == WIDTH'(1));
  assign status_o.base_zero     = (base_q == '0);
  assign status_o.mul_last      = (cnt_q == '0);

  assign power_o = 64'(res_q);

endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
//
// A request (base_i, exponent_i) is taken when start is high and busy is low;
// power_o is valid for the single cycle in which done_o is high, and must be
// taken then since the block cannot be stalled. All products go through one
// bit-serial modular multiplier. A request needs one reduction of the base,
// one multiply per set exponent bit and one squaring per exponent bit below
// the highest set one. Zero exponent, a modulus of one or a zero base finish
// without using the multiplier. The next request can be taken in the cycle
// after the strobe. The modulus is written through cfg_valid_i/cfg_data_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce.
module modular_exponentiation #(
  parameter int unsigned WIDTH = mexp_pkg::DEF_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] base_i,
  input  logic [63:0] exponent_i,
  output logic        done_o,
  output logic [63:0] power_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;
  logic              busy_int;

  assign busy        = busy_int;
  assign cfg_ready_o = 1'b1;

  mexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy_int),
    .done_o   (done_o)
  );

  mexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .power_o    (power_o)
  );

endmodule
